/* rtl/bitmap_allocator_engine_macros.svh */
// ----------------------------------------------------------------------------
// Bitmap allocator engine assertion macros
// Shared concurrent assertion forms used by the engine's port checker.
// ----------------------------------------------------------------------------
`ifndef BITMAP_ALLOCATOR_ENGINE_MACROS_SVH
`define BITMAP_ALLOCATOR_ENGINE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BAE_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("bitmap allocator engine check failed");

// Next-cycle implication, disabled while reset is asserted.
`define BAE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("bitmap allocator engine check failed");

`endif

/* rtl/bae_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitmap allocator engine package
// Command and result types, opcodes and fixed field widths.
// ----------------------------------------------------------------------------
package bae_pkg;

    localparam int POS_W  = 14;   // bit positions, including area ends
    localparam int SIZE_W = 13;   // map size and population count

    localparam logic [SIZE_W-1:0] MAP_SIZE_RST = 13'd4096;
    localparam int                MAX_SIZE     = 8191;

    localparam logic [2:0] OP_SET_RUN   = 3'd0;
    localparam logic [2:0] OP_CLR_RUN   = 3'd1;
    localparam logic [2:0] OP_NEXT_ZERO = 3'd2;
    localparam logic [2:0] OP_NEXT_SET  = 3'd3;
    localparam logic [2:0] OP_ZERO_AREA = 3'd4;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [11:0] start_bit;
        logic [12:0] run_length;
        logic [11:0] area_mask;
        logic [11:0] area_offset;
    } t_cmd;

    typedef struct packed {
        logic [13:0] result_index;
        logic        found;
        logic [12:0] set_count;
        logic        all_clear;
        logic        all_set;
    } t_result;

    // Outcome of a search within one bitmap word.
    typedef struct packed {
        logic             hit;
        logic [POS_W-1:0] pos;
    } t_scan_res;

endpackage

/* rtl/bitmap_allocator_engine.sv */
`timescale 1ns / 1ps
// Sequence: the command first walks its words; runs and bit searches walk each word once, while
// a zero-area search adds find, align and check steps per candidate start and may rewalk words.
// A population sweep over the words in use follows, and then the result strobe.
// One command at a time; the next can be accepted in the cycle after the strobe.
// Reset: synchronous, active low; a clearing pass then zeroes all words (64 at the defaults).
// ----------------------------------------------------------------------------
// Bitmap allocator engine
// Allocation bitmap held in a word RAM, with run set/clear, next zero/set
// search, aligned zero-area search and a population report on every result.
// ----------------------------------------------------------------------------
module bitmap_allocator_engine #(
    parameter int MAP_BITS  = 4096,
    parameter int WORD_BITS = 64
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    // Command channel
    input  logic             start,
    output logic             busy,
    input  bae_pkg::t_cmd    i_cmd,
    // Result channel
    output logic             o_done,
    output bae_pkg::t_result o_result,
    // Configuration port
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [2:0]       paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import bae_pkg::*;

    localparam int WLOG      = $clog2(WORD_BITS);
    localparam int NUM_WORDS = (MAP_BITS + WORD_BITS - 1) / WORD_BITS;
    localparam int AW        = NUM_WORDS > 1 ? $clog2(NUM_WORDS) : 1;
    localparam int POP_W     = $clog2(WORD_BITS + 1);
    localparam int MAP_CAP   = MAP_BITS > MAX_SIZE ? MAX_SIZE : MAP_BITS;

    // Sequencer states.
    localparam logic [3:0] S_CLR       = 4'd0;
    localparam logic [3:0] S_IDLE      = 4'd1;
    localparam logic [3:0] S_SCAN_RD   = 4'd2;
    localparam logic [3:0] S_SCAN_EV   = 4'd3;
    localparam logic [3:0] S_RMW_RD    = 4'd4;
    localparam logic [3:0] S_RMW_EV    = 4'd5;
    localparam logic [3:0] S_AREA_FIND = 4'd6;
    localparam logic [3:0] S_ALIGN     = 4'd7;
    localparam logic [3:0] S_AREA_CHK  = 4'd8;
    localparam logic [3:0] S_CNT_INIT  = 4'd9;
    localparam logic [3:0] S_CNT_RD    = 4'd10;
    localparam logic [3:0] S_CNT_EV    = 4'd11;
    localparam logic [3:0] S_DONE      = 4'd12;

    // Control registers.
    logic [3:0]        r_state, n_state;
    logic [AW-1:0]     r_clr, n_clr;
    logic [SIZE_W-1:0] r_map_size;

    // Working registers of the current transaction.
    t_cmd              r_cmd, n_cmd;
    logic [POS_W-1:0]  r_n, n_n;
    logic [POS_W-1:0]  r_from, n_from;
    logic [POS_W-1:0]  r_lim, n_lim;
    logic [POS_W-1:0]  r_idx, n_idx;
    logic              r_want, n_want;
    logic              r_phase, n_phase;
    logic [POS_W-1:0]  r_res, n_res;
    logic              r_found, n_found;
    logic [SIZE_W-1:0] r_cnt, n_cnt;

    // Memory and word unit connections.
    logic                 w_we;
    logic [AW-1:0]        w_waddr, w_raddr;
    logic [WORD_BITS-1:0] w_wdata, w_rdata, w_mask;
    logic [POP_W-1:0]     w_pop;
    t_scan_res            w_scan;

    logic [POS_W-1:0]  w_base, w_next_base, w_word_idx;
    logic [SIZE_W-1:0] w_eff;
    logic [POS_W-1:0]  w_eff14, w_start14, w_run_end, w_sum, w_hit_pos;
    logic [POS_W:0]    w_area_end;
    logic [POS_W-1:0]  w_amask14, w_aoff14;
    logic              w_scan_end;

    assign w_eff = (r_map_size > SIZE_W'(MAP_CAP)) ? SIZE_W'(MAP_CAP) : r_map_size;
    assign w_eff14   = POS_W'(w_eff);
    assign w_start14 = POS_W'(i_cmd.start_bit);
    assign w_run_end = w_start14 + POS_W'(i_cmd.run_length);

    // Word walk: the current word's first bit, the next word's first bit.
    assign w_base      = r_from & ~POS_W'(WORD_BITS - 1);
    assign w_next_base = w_base + POS_W'(WORD_BITS);
    assign w_word_idx  = r_from >> WLOG;
    assign w_raddr     = AW'(w_word_idx);
    assign w_scan_end  = w_next_base >= r_lim;

    // The area end keeps one extra bit so that a long area past a large map
    // still compares above the map size.
    assign w_amask14  = POS_W'(r_cmd.area_mask);
    assign w_aoff14   = POS_W'(r_cmd.area_offset);
    assign w_sum      = r_idx + w_aoff14 + w_amask14;
    assign w_area_end = {1'b0, r_idx} + (POS_W + 1)'(r_cmd.run_length);
    assign w_hit_pos  = w_scan.hit ? w_scan.pos : r_lim;

    bae_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (NUM_WORDS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    bae_word_unit #(
        .WORD_BITS (WORD_BITS)
    ) u_word (
        .i_data (w_rdata),
        .i_base (w_base),
        .i_lo   (r_from),
        .i_hi   (r_lim),
        .i_want (r_want),
        .o_mask (w_mask),
        .o_scan (w_scan),
        .o_pop  (w_pop)
    );

    // The write port serves the clearing pass and the run write-back.
    always_comb begin
        w_we    = (r_state == S_CLR) || (r_state == S_RMW_EV);
        w_waddr = (r_state == S_CLR) ? r_clr : w_raddr;
        if (r_state == S_CLR) begin
            w_wdata = '0;
        end else if (r_cmd.opcode == OP_SET_RUN) begin
            w_wdata = w_rdata | w_mask;
        end else begin
            w_wdata = w_rdata & ~w_mask;
        end
    end

    always_comb begin
        n_state = r_state;
        n_clr   = r_clr;
        n_cmd   = r_cmd;
        n_n     = r_n;
        n_from  = r_from;
        n_lim   = r_lim;
        n_idx   = r_idx;
        n_want  = r_want;
        n_phase = r_phase;
        n_res   = r_res;
        n_found = r_found;
        n_cnt   = r_cnt;

        unique case (r_state)
            S_CLR: begin
                n_clr = r_clr + AW'(1);
                if (r_clr == AW'(NUM_WORDS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    n_cmd   = i_cmd;
                    n_n     = w_eff14;
                    n_res   = '0;
                    n_found = 1'b0;
                    n_from  = w_start14;
                    n_phase = 1'b0;
                    n_state = S_CNT_INIT;
                    unique case (i_cmd.opcode)
                        OP_SET_RUN, OP_CLR_RUN: begin
                            // Runs are clipped at the map end.
                            n_lim = (w_run_end > w_eff14) ? w_eff14 : w_run_end;
                            if (w_start14 < n_lim) begin
                                n_state = S_RMW_RD;
                            end
                        end
                        OP_NEXT_ZERO, OP_NEXT_SET: begin
                            n_want = (i_cmd.opcode == OP_NEXT_SET);
                            n_lim  = w_eff14;
                            if (w_start14 >= w_eff14) begin
                                n_res = w_eff14;
                            end else begin
                                n_state = S_SCAN_RD;
                            end
                        end
                        OP_ZERO_AREA: begin
                            n_state = S_AREA_FIND;
                        end
                        default: begin
                            n_state = S_CNT_INIT;
                        end
                    endcase
                end
            end
            S_SCAN_RD: begin
                n_state = S_SCAN_EV;
            end
            S_SCAN_EV: begin
                if (!w_scan.hit && !w_scan_end) begin
                    n_from  = w_next_base;
                    n_state = S_SCAN_RD;
                end else if (r_cmd.opcode != OP_ZERO_AREA) begin
                    n_res   = w_hit_pos;
                    n_found = w_hit_pos < r_n;
                    n_state = S_CNT_INIT;
                end else if (!r_phase) begin
                    // First free bit, or the map end if none; align it next.
                    n_idx   = w_hit_pos;
                    n_state = S_ALIGN;
                end else if (w_scan.hit) begin
                    // A set bit inside the candidate area: resume after it.
                    n_from  = w_scan.pos + POS_W'(1);
                    n_phase = 1'b0;
                    n_state = S_AREA_FIND;
                end else begin
                    n_res   = r_idx;
                    n_found = r_idx < r_n;
                    n_state = S_CNT_INIT;
                end
            end
            S_AREA_FIND: begin
                if (r_from >= r_n) begin
                    n_idx   = r_n;
                    n_state = S_ALIGN;
                end else begin
                    n_lim   = r_n;
                    n_want  = 1'b0;
                    n_phase = 1'b0;
                    n_state = S_SCAN_RD;
                end
            end
            S_ALIGN: begin
                n_idx   = (w_sum & ~w_amask14) - w_aoff14;
                n_state = S_AREA_CHK;
            end
            S_AREA_CHK: begin
                if (w_area_end > {1'b0, r_n}) begin
                    n_res   = w_area_end[POS_W-1:0];
                    n_state = S_CNT_INIT;
                end else if (r_cmd.run_length == '0) begin
                    n_res   = r_idx;
                    n_found = r_idx < r_n;
                    n_state = S_CNT_INIT;
                end else begin
                    n_from  = r_idx;
                    n_lim   = w_area_end[POS_W-1:0];
                    n_want  = 1'b1;
                    n_phase = 1'b1;
                    n_state = S_SCAN_RD;
                end
            end
            S_RMW_RD: begin
                n_state = S_RMW_EV;
            end
            S_RMW_EV: begin
                if (w_scan_end) begin
                    n_state = S_CNT_INIT;
                end else begin
                    n_from  = w_next_base;
                    n_state = S_RMW_RD;
                end
            end
            S_CNT_INIT: begin
                n_from  = '0;
                n_lim   = r_n;
                n_cnt   = '0;
                n_state = (r_n == '0) ? S_DONE : S_CNT_RD;
            end
            S_CNT_RD: begin
                n_state = S_CNT_EV;
            end
            S_CNT_EV: begin
                n_cnt = r_cnt + SIZE_W'(w_pop);
                if (w_scan_end) begin
                    n_state = S_DONE;
                end else begin
                    n_from  = w_next_base;
                    n_state = S_CNT_RD;
                end
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLR;
            r_clr      <= '0;
            r_map_size <= MAP_SIZE_RST;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            if (psel && penable && pwrite && !paddr[2]) begin
                r_map_size <= pwdata[SIZE_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd   <= n_cmd;
        r_n     <= n_n;
        r_from  <= n_from;
        r_lim   <= n_lim;
        r_idx   <= n_idx;
        r_want  <= n_want;
        r_phase <= n_phase;
        r_res   <= n_res;
        r_found <= n_found;
        r_cnt   <= n_cnt;
    end

    assign busy   = (r_state != S_IDLE);
    assign o_done = (r_state == S_DONE);

    assign o_result.result_index = r_res;
    assign o_result.found        = r_found;
    assign o_result.set_count    = r_cnt;
    assign o_result.all_clear    = (r_cnt == '0);
    assign o_result.all_set      = (POS_W'(r_cnt) == r_n);

    assign pready = 1'b1;
    assign prdata = paddr[2] ? 32'd0 : 32'(r_map_size);
endmodule

/* rtl/bae_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bae_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                                      i_clk,
    input  logic                                      i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                          i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                          o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

/* rtl/bae_word_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitmap word unit
// Masks one word to a bit range, finds the first bit of the wanted value
// inside it and counts the set bits inside it.
// ----------------------------------------------------------------------------
module bae_word_unit #(
    parameter int WORD_BITS = 64
) (
    input  logic [WORD_BITS-1:0]          i_data,
    input  logic [bae_pkg::POS_W-1:0]     i_base,
    input  logic [bae_pkg::POS_W-1:0]     i_lo,
    input  logic [bae_pkg::POS_W-1:0]     i_hi,
    input  logic                          i_want,
    output logic [WORD_BITS-1:0]          o_mask,
    output bae_pkg::t_scan_res            o_scan,
    output logic [$clog2(WORD_BITS+1)-1:0] o_pop
);
    import bae_pkg::*;

    localparam int WLOG  = $clog2(WORD_BITS);
    localparam int POP_W = $clog2(WORD_BITS + 1);

    logic [POS_W-1:0]     w_pos;
    logic [WORD_BITS-1:0] w_sel;
    logic [WLOG-1:0]      w_first;
    logic [POP_W-1:0]     w_pop;

    always_comb begin
        for (int j = 0; j < WORD_BITS; j++) begin
            w_pos     = i_base + POS_W'(j);
            o_mask[j] = (w_pos >= i_lo) && (w_pos < i_hi);
        end
        w_sel = (i_want ? i_data : ~i_data) & o_mask;

        // Lowest selected bit wins.
        w_first = '0;
        for (int j = WORD_BITS - 1; j >= 0; j--) begin
            if (w_sel[j]) begin
                w_first = WLOG'(j);
            end
        end
        o_scan.hit = |w_sel;
        o_scan.pos = i_base + POS_W'(w_first);

        w_pop = '0;
        for (int j = 0; j < WORD_BITS; j++) begin
            w_pop = w_pop + POP_W'(i_data[j] & o_mask[j]);
        end
        o_pop = w_pop;
    end
endmodule

/* rtl/bae_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitmap allocator engine port checker
// Watches the command and result ports of the engine over time.
// ----------------------------------------------------------------------------
`include "bitmap_allocator_engine_macros.svh"

module bae_checker (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             start,
    input logic             busy,
    input logic             o_done,
    input bae_pkg::t_result o_result
);
    import bae_pkg::*;

    `BAE_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy)
    `BAE_ASSERT_NOW(a_done_in_flight, i_clk, i_rst_n, o_done, busy)
    `BAE_ASSERT_NEXT(a_done_frees, i_clk, i_rst_n, o_done, !busy && !o_done)
    `BAE_ASSERT_NOW(a_clear_count, i_clk, i_rst_n, o_done, o_result.all_clear == (o_result.set_count == '0))
endmodule

bind bitmap_allocator_engine bae_checker u_bae_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_done   (o_done),
    .o_result (o_result)
);

/* test/tb_bitmap_allocator_engine.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitmap allocator engine testbench
// Drives set/clear runs, bit searches and aligned zero-area searches through
// the command channel, under several map sizes written over the APB port.
// An in-bench model or a typed row value predicts every result; strobes are
// checked field by field against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module tb_bitmap_allocator_engine;
    import bae_pkg::*;

    // Map geometry of the instance under test.
    localparam int MAP_BITS   = 4096;
    localparam int RAND_ITEMS = 1520;
    localparam int CMD_W      = $bits(t_cmd);
    // A zero-area search over many short holes can run long; the limit allows
    // for that on every command of the run.
    localparam int CYCLE_LIMIT = 400000000;
    localparam logic [2:0] REG_MAP_SIZE = 3'd0;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    t_cmd        i_cmd;
    logic        o_done;
    t_result     o_result;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    bitmap_allocator_engine #(
        .MAP_BITS  (MAP_BITS),
        .WORD_BITS (64)
    ) u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_cmd    (i_cmd),
        .o_done   (o_done),
        .o_result (o_result),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // 10 ns clock.
    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // ------------------------------------------------------------------
    // Shadow copy of the allocator state. The bitmap is updated as each
    // transaction is accepted, the map size as its write completes, so the
    // prediction always reflects exactly the commands the block has taken.
    // ------------------------------------------------------------------
    bit [MAP_BITS-1:0] shadow_map;
    logic [12:0]       shadow_map_size;
    t_result           pending_results[$];

    int unsigned n_errors;
    int unsigned n_checked;
    int unsigned n_found;
    int unsigned n_sizes;
    longint unsigned cycle_count;
    bit          quiet_tail;

    // First position in [from, lim) holding the wanted value, else lim.
    function automatic longint unsigned scan_map(longint unsigned from,
                                                 longint unsigned lim, bit want);
        longint unsigned p;
        for (p = from; p < lim; p++) begin
            if (shadow_map[p % MAP_BITS] == want)
                return p;
        end
        return lim;
    endfunction

    // Applies one command to the shadow bitmap and returns what the block
    // should report for it.
    function automatic t_result apply_allocator_cmd(t_cmd c);
        t_result         r;
        longint unsigned n, res, endp, p, cnt, from, idx, hit;
        longint unsigned amask, aoff, len;
        bit              fnd, searching;
        n     = (shadow_map_size > MAP_BITS) ? MAP_BITS : shadow_map_size;
        res   = 0;
        fnd   = 1'b0;
        amask = c.area_mask;
        aoff  = c.area_offset;
        len   = c.run_length;
        case (c.opcode)
            OP_SET_RUN, OP_CLR_RUN: begin
                // Runs are clipped at the map size; bits beyond stay as they are.
                endp = c.start_bit + len;
                if (endp > n)
                    endp = n;
                for (p = c.start_bit; p < endp; p++)
                    shadow_map[p] = (c.opcode == OP_SET_RUN);
            end
            OP_NEXT_ZERO, OP_NEXT_SET: begin
                if (c.start_bit >= n) begin
                    res = n;
                end else begin
                    res = scan_map(c.start_bit, n, c.opcode == OP_NEXT_SET);
                    fnd = (res < n);
                end
            end
            OP_ZERO_AREA: begin
                // Walk candidate starts: align the next zero, then restart
                // just past any set bit found inside the candidate area.
                from      = c.start_bit;
                searching = 1'b1;
                while (searching) begin
                    idx  = (from >= n) ? n : scan_map(from, n, 1'b0);
                    idx  = ((idx + aoff + amask) & ~amask) - aoff;
                    endp = idx + len;
                    if (endp > n) begin
                        res       = endp;
                        searching = 1'b0;
                    end else begin
                        hit = scan_map(idx, endp, 1'b1);
                        if (hit < endp) begin
                            from = hit + 1;
                        end else begin
                            res       = idx;
                            fnd       = (idx < n);
                            searching = 1'b0;
                        end
                    end
                end
            end
            default: ;
        endcase
        cnt = 0;
        for (p = 0; p < n; p++)
            cnt += shadow_map[p];
        r.result_index = res[13:0];
        r.found        = fnd;
        r.set_count    = cnt[12:0];
        r.all_clear    = (cnt == 0);
        r.all_set      = (cnt == n);
        return r;
    endfunction

    task automatic report_mismatch(string field, longint unsigned got,
                                   longint unsigned want);
        n_errors++;
        $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, field, got, want);
    endtask

    // ------------------------------------------------------------------
    // Result checker. The receiver cannot stall, so every strobe is a
    // completed transaction and is matched against the oldest prediction.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_done) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result", o_result.result_index, 0);
            end else begin
                want = pending_results.pop_front();
                n_checked++;
                if (want.found)
                    n_found++;
                if (o_result.result_index !== want.result_index)
                    report_mismatch("result_index", o_result.result_index,
                                    want.result_index);
                if (o_result.found !== want.found)
                    report_mismatch("found", o_result.found, want.found);
                if (o_result.set_count !== want.set_count)
                    report_mismatch("set_count", o_result.set_count, want.set_count);
                if (o_result.all_clear !== want.all_clear)
                    report_mismatch("all_clear", o_result.all_clear, want.all_clear);
                if (o_result.all_set !== want.all_set)
                    report_mismatch("all_set", o_result.all_set, want.all_set);
            end
        end
    end

    // Watchdog against a hung handshake.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Presents one command from the falling edge and holds it until a rising
    // edge sees busy low. Start is left high so a following command can go
    // back to back; the caller lowers it when it idles.
    task automatic send_cmd(t_cmd c, bit use_typed, t_result typed);
        t_result predicted;
        @(negedge i_clk);
        start = 1'b1;
        i_cmd = c;
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
        predicted = apply_allocator_cmd(c);
        pending_results.push_back(use_typed ? typed : predicted);
    endtask

    // Random gap on the command side, skipped in the quiet tail of the run.
    task automatic maybe_idle();
        int k;
        if (!quiet_tail && $urandom_range(0, 3) == 0) begin
            k = $urandom_range(1, 14);
            @(negedge i_clk);
            start = 1'b0;
            i_cmd = t_cmd'(CMD_W'($urandom));
            repeat (k - 1) @(negedge i_clk);
        end
    endtask

    // Waits until the block is idle with nothing outstanding, then writes
    // the map size register through a setup phase and then an access phase.
    task automatic write_map_size(logic [12:0] size);
        @(negedge i_clk);
        start = 1'b0;
        while (pending_results.size() != 0 || busy)
            @(negedge i_clk);
        psel    = 1'b1;
        pwrite  = 1'b1;
        penable = 1'b0;
        paddr   = REG_MAP_SIZE;
        pwdata  = {$urandom_range(0, 1) ? 19'h7FFFF : 19'h0, size};
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        shadow_map_size = size;
        n_sizes++;
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // Random command. Mostly short runs and masks of the form 2^k-1 so that
    // searches meet a realistic mix of holes; a share of fully random
    // fields keeps every input bit toggling.
    function automatic t_cmd random_cmd();
        t_cmd c;
        int   sel;
        c   = t_cmd'(CMD_W'({$urandom, $urandom}));
        sel = $urandom_range(0, 99);
        if (sel < 85) begin
            c.opcode = (sel < 70) ? 3'($urandom_range(0, 4)) : OP_ZERO_AREA;
            if ($urandom_range(0, 3) != 0)
                c.run_length = 13'($urandom_range(0, 80));
            if ($urandom_range(0, 3) != 0)
                c.area_mask = 12'((1 << $urandom_range(0, 6)) - 1);
            if ($urandom_range(0, 1) != 0)
                c.area_offset = 12'($urandom_range(0, 15));
            if (shadow_map_size < MAP_BITS && $urandom_range(0, 2) != 0)
                c.start_bit = 12'($urandom_range(0, shadow_map_size + 2));
        end
        return c;
    endfunction

    // ------------------------------------------------------------------
    // Directed table. Rows with a typed result are checked against that
    // value right after reset with the full map; the rest use the model.
    // ------------------------------------------------------------------
    typedef struct {
        t_cmd    cmd;
        bit      typed;
        t_result result;
    } t_directed_row;

    t_directed_row directed_rows[$];

    function automatic t_directed_row mk_row(logic [2:0] op, int sb, int len, int msk,
                                             int off, bit typed, int idx, bit fnd,
                                             int cnt, bit clr, bit full);
        t_directed_row row;
        row.cmd    = '{op, 12'(sb), 13'(len), 12'(msk), 12'(off)};
        row.typed  = typed;
        row.result = '{14'(idx), fnd, 13'(cnt), clr, full};
        return row;
    endfunction

    initial begin
        t_cmd          c;
        t_result       none;
        logic [12:0]   size_plan[$];
        int            items_per_phase;
        none            = '0;
        start           = 1'b0;
        i_cmd           = '0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        shadow_map      = '0;
        shadow_map_size = MAP_SIZE_RST;
        n_errors        = 0;
        n_checked       = 0;
        n_found         = 0;
        n_sizes         = 0;
        cycle_count     = 0;
        quiet_tail      = 1'b0;
        i_rst_n         = 1'b0;
        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Empty full map: searches from zero, full-length area, then fill it and search again.
        directed_rows.push_back(mk_row(OP_NEXT_ZERO, 0, 0, 0, 0, 1, 0, 1, 0, 1, 0));
        directed_rows.push_back(mk_row(OP_NEXT_SET, 0, 0, 0, 0, 1, 4096, 0, 0, 1, 0));
        directed_rows.push_back(mk_row(OP_ZERO_AREA, 0, 4096, 0, 0, 1, 0, 1, 0, 1, 0));
        directed_rows.push_back(mk_row(OP_SET_RUN, 0, 4096, 0, 0, 1, 0, 0, 4096, 0, 1));
        directed_rows.push_back(mk_row(OP_NEXT_ZERO, 0, 0, 0, 0, 1, 4096, 0, 4096, 0, 1));
        directed_rows.push_back(mk_row(OP_ZERO_AREA, 0, 1, 0, 0, 1, 4097, 0, 4096, 0, 1));
        // Unused opcodes leave the map alone.
        directed_rows.push_back(mk_row(3'd5, 7, 9, 0, 0, 1, 0, 0, 4096, 0, 1));
        directed_rows.push_back(mk_row(3'd7, 4095, 8191, 4095, 4095, 1, 0, 0, 4096, 0, 1));
        // Run that reaches past the map end is clipped; then a cleared stretch with a short set run inside.
        directed_rows.push_back(mk_row(OP_CLR_RUN, 4095, 8191, 0, 0, 1, 0, 0, 4095, 0, 0));
        directed_rows.push_back(mk_row(OP_NEXT_ZERO, 4095, 0, 0, 0, 1, 4095, 1, 4095, 0, 0));
        directed_rows.push_back(mk_row(OP_CLR_RUN, 100, 300, 0, 0, 0, 0, 0, 0, 0, 0));
        directed_rows.push_back(mk_row(OP_SET_RUN, 130, 5, 0, 0, 0, 0, 0, 0, 0, 0));
        directed_rows.push_back(mk_row(OP_NEXT_SET, 100, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        // Aligned areas: mask, offset, a set bit forcing a restart.
        directed_rows.push_back(mk_row(OP_ZERO_AREA, 90, 40, 63, 0, 0, 0, 0, 0, 0, 0));
        directed_rows.push_back(mk_row(OP_ZERO_AREA, 0, 16, 15, 3, 0, 0, 0, 0, 0, 0));
        // Zero-length area, and a mask that is not a power of two minus one.
        directed_rows.push_back(mk_row(OP_ZERO_AREA, 101, 0, 7, 0, 0, 0, 0, 0, 0, 0));
        directed_rows.push_back(mk_row(OP_ZERO_AREA, 100, 8, 10, 5, 0, 0, 0, 0, 0, 0));
        directed_rows.push_back(mk_row(OP_ZERO_AREA, 4095, 0, 4095, 4095, 0, 0, 0, 0, 0, 0));
        directed_rows.push_back(mk_row(OP_CLR_RUN, 0, 8191, 4095, 4095, 0, 0, 0, 0, 0, 0));

        foreach (directed_rows[i]) begin
            send_cmd(directed_rows[i].cmd, directed_rows[i].typed, directed_rows[i].result);
            maybe_idle();
        end

        // Map sizes: the extremes, zero, a word edge, odd sizes, beyond MAP_BITS.
        size_plan = '{13'd1, 13'd0, 13'd8191, 13'd64, 13'd100, 13'd4095, 13'd777, 13'd4096};
        items_per_phase = RAND_ITEMS / size_plan.size();
        foreach (size_plan[ph]) begin
            write_map_size(size_plan[ph]);
            // A zero-size map gets two searches of its own up front.
            if (size_plan[ph] == 0) begin
                c = '{OP_NEXT_ZERO, 12'd0, 13'd0, 12'd0, 12'd0};
                send_cmd(c, 1'b0, none);
                c = '{OP_ZERO_AREA, 12'd0, 13'd0, 12'd0, 12'd0};
                send_cmd(c, 1'b0, none);
            end
            quiet_tail = (ph == size_plan.size() - 1);
            repeat (items_per_phase) begin
                send_cmd(random_cmd(), 1'b0, none);
                maybe_idle();
            end
        end

        @(negedge i_clk);
        start = 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        // Let any stray strobe show itself.
        repeat (600) @(posedge i_clk);
        if (pending_results.size() != 0)
            report_mismatch("results left over", pending_results.size(), 0);

        $display("covered %0d results (%0d with found set) over %0d map sizes",
                 n_checked, n_found, n_sizes + 1);
        if (n_errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("%0d mismatches", n_errors);
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
